// File: rtl/core/prsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG row Sub filter package
// Shared constants, register indexes and types of the row filter block.
// ----------------------------------------------------------------------------
package prsf_pkg;

	// Largest filter distance in bytes and the index width of the history.
	localparam int MAX_PIXEL_BYTES = 8;
	localparam int SLOT_W          = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

	// Field widths.
	localparam int BYTE_W = 8;
	localparam int BPP_W  = 4;
	localparam int COL_W  = 20;
	localparam int CFG_W  = 20;
	localparam int IDX_W  = 2;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd0;
	localparam logic [IDX_W-1:0] REG_ROW_BYTES       = 2'd1;
	localparam logic [IDX_W-1:0] REG_WIDE_SAMPLES    = 2'd2;
	localparam logic [IDX_W-1:0] REG_FILTER_ENABLE   = 2'd3;

	// Filter-type tag values.
	localparam logic [BYTE_W-1:0] TAG_NONE = 8'd0;
	localparam logic [BYTE_W-1:0] TAG_SUB  = 8'd1;

	// One result byte with its tag flag.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              tag;
	} res_entry_t;

	// Number of results that one input byte produces (zero to two).
	typedef logic [1:0] res_cnt_t;

	// The results of one input byte, first entry delivered first.
	typedef struct packed {
		res_cnt_t   cnt;
		res_entry_t e0;
		res_entry_t e1;
	} res_group_t;

endpackage

// File: rtl/core/prsf_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG row Sub filter result buffer
// Holds the results of one input byte and delivers them one per transfer.
// ----------------------------------------------------------------------------
module prsf_out_buf (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  prsf_pkg::res_group_t      grp,
	output logic                      ready,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [prsf_pkg::BYTE_W-1:0] out_byte,
	output logic                      is_tag,
	output logic                      last_of_run
);
	import prsf_pkg::*;

	res_cnt_t   cnt_q;
	res_entry_t e0_q;
	res_entry_t e1_q;
	logic       take;

	// The head entry is offered; the last one left closes the run.
	assign out_valid   = (cnt_q != 2'd0);
	assign take        = out_valid && !out_stall;
	assign out_byte    = e0_q.data;
	assign is_tag      = e0_q.tag;
	assign last_of_run = (cnt_q == 2'd1);

	// A new group may enter once the buffer empties in this cycle.
	assign ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && !out_stall);

	// Occupancy count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= grp.cnt;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Entry payload; the second entry moves up after the first transfer.
	always_ff @(posedge clk) begin
		if (load) begin
			e0_q <= grp.e0;
			e1_q <= grp.e1;
		end else if (take) begin
			e0_q <= e1_q;
		end
	end

	// A group is never loaded over results that are still pending.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && take)))
		else $error("result group loaded over pending results");

	// A loaded group of two keeps the second result for the following cycle.
	a_pair_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(load && (grp.cnt == 2'd2)) |=> (out_valid && !last_of_run))
		else $error("second result of a pair lost");

	// The count stays within one group.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result count out of range");

endmodule

// File: rtl/core/png_row_sub_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG row Sub filter
// Emits a filter-type tag before each row, then the bytes of the row either
// Sub-filtered (optionally pair-swapped for 16-bit samples) or copied raw.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  in        input      in_valid / in_stall  data_byte
//  out       output     out_valid/ out_stall out_byte, is_tag, last_of_run
//  cfg       input      cfg_we               cfg_index, cfg_data
//
//  An input byte is filtered in the cycle of its transfer; its results are
//  offered from the next cycle on, one per cycle while the output is not stalled.
//  A byte with one result is taken in every cycle while the output is not
//  stalled, a held even byte of wide filtered mode that yields none in every
//  cycle. A byte with two results (tag plus data, or a swapped pair) holds
//  back a next byte that yields a result, so swapped pairs keep the full rate.
//  Reset clears the registers to their defaults, the history to zero and
//  starts a new row; a stalled output holds its byte and stalls the input.
// ----------------------------------------------------------------------------
module png_row_sub_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [prsf_pkg::IDX_W-1:0]    cfg_index,
	input  logic [prsf_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [prsf_pkg::BYTE_W-1:0]   data_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [prsf_pkg::BYTE_W-1:0]   out_byte,
	output logic                          is_tag,
	output logic                          last_of_run
);
	import prsf_pkg::*;

	// Configuration registers.
	logic [BPP_W-1:0] bpp_q;
	logic [COL_W-1:0] row_bytes_q;
	logic             wide_q;
	logic             filter_q;

	// Row state.
	logic [BYTE_W-1:0] hist_q [MAX_PIXEL_BYTES];
	logic [SLOT_W-1:0] res_q  [MAX_PIXEL_BYTES];
	logic [COL_W-1:0]  col_q;
	logic [BYTE_W-1:0] held_q;

	logic              ready;
	logic              no_res;
	logic              accept;
	logic              load;
	logic [SLOT_W-1:0] dist_m1;
	logic [COL_W-1:0]  len_m1;
	logic              last;
	logic [SLOT_W-1:0] slot;
	logic [BYTE_W-1:0] prev;
	logic [BYTE_W-1:0] filt;
	logic              wide_filt;
	res_entry_t        tag_e;
	res_entry_t        d0_e;
	res_entry_t        d1_e;
	res_cnt_t          n_data;
	res_group_t        grp;

	// A byte with no result needs no room in the result buffer.
	assign no_res   = (grp.cnt == 2'd0);
	assign accept   = in_valid && (ready || no_res);
	assign in_stall = !(ready || no_res);
	assign load     = accept && !no_res;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q       <= BPP_W'(1);
			row_bytes_q <= COL_W'(1);
			wide_q      <= 1'b0;
			filter_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BYTES_PER_PIXEL: bpp_q       <= cfg_data[BPP_W-1:0];
				REG_ROW_BYTES:       row_bytes_q <= cfg_data[COL_W-1:0];
				REG_WIDE_SAMPLES:    wide_q      <= cfg_data[0];
				REG_FILTER_ENABLE:   filter_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Distance clamped to one through the history depth, held minus one.
	always_comb begin
		if (bpp_q == '0) begin
			dist_m1 = '0;
		end else if (32'(bpp_q) > MAX_PIXEL_BYTES) begin
			dist_m1 = SLOT_W'(MAX_PIXEL_BYTES - 1);
		end else begin
			dist_m1 = SLOT_W'(bpp_q - BPP_W'(1));
		end
	end

	// Row end: a zero length acts as one byte per row.
	assign len_m1 = (row_bytes_q == '0) ? '0 : (row_bytes_q - COL_W'(1));
	assign last   = (col_q >= len_m1);

	// Column modulo the distance comes from the counter kept for that distance.
	assign slot = res_q[dist_m1];
	assign prev = (col_q < (COL_W'(dist_m1) + COL_W'(1))) ? '0 : hist_q[slot];
	assign filt = filter_q ? (data_byte - prev) : data_byte;

	// Result group of this byte: optional tag, then zero to two data bytes.
	assign wide_filt = filter_q && wide_q;
	always_comb begin
		tag_e.data = filter_q ? TAG_SUB : TAG_NONE;
		tag_e.tag  = 1'b1;
		d0_e.data  = filt;
		d0_e.tag   = 1'b0;
		d1_e.data  = held_q;
		d1_e.tag   = 1'b0;
		if (!wide_filt) begin
			n_data = 2'd1;
		end else if (col_q[0]) begin
			n_data = 2'd2;
		end else if (last) begin
			n_data = 2'd1;
		end else begin
			n_data = 2'd0;
		end
		if (col_q == '0) begin
			grp.cnt = n_data + 2'd1;
			grp.e0  = tag_e;
			grp.e1  = d0_e;
		end else begin
			grp.cnt = n_data;
			grp.e0  = d0_e;
			grp.e1  = d1_e;
		end
	end

	// Column, residue counters, history and the held even byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			held_q <= '0;
			for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
				hist_q[i] <= '0;
				res_q[i]  <= '0;
			end
		end else if (accept) begin
			col_q        <= last ? '0 : (col_q + COL_W'(1));
			hist_q[slot] <= data_byte;
			if (wide_filt && !col_q[0] && !last) begin
				held_q <= filt;
			end
			for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
				if (last || (res_q[i] == SLOT_W'(i))) begin
					res_q[i] <= '0;
				end else begin
					res_q[i] <= res_q[i] + SLOT_W'(1);
				end
			end
		end
	end

	prsf_out_buf u_out_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.grp         (grp),
		.ready       (ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.is_tag      (is_tag),
		.last_of_run (last_of_run)
	);

	// The first byte of a row is always preceded by its tag.
	a_tag_first: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (col_q == '0)) |=> (out_valid && is_tag))
		else $error("row started without a tag");

	// An odd byte in wide filtered mode yields a swapped pair.
	a_odd_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && wide_filt && col_q[0]) |=> (out_valid && !is_tag && !last_of_run))
		else $error("swapped pair missing");

	// The column restarts right after the byte that ends a row.
	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last) |=> (col_q == '0))
		else $error("column did not wrap at row end");

endmodule

// File: dv/png_row_sub_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG row Sub filter testbench
// Streams raw row bytes into the filter under random input gaps and output
// stalls, predicts every tag and data byte in step with each accepted
// transfer, and checks the output stream byte by byte in order.
// ----------------------------------------------------------------------------
module png_row_sub_filter_tb;
	import prsf_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int TIMEOUT_CYCLES = 500000;
	localparam int RANDOM_ITEMS   = 280;
	localparam int DRAIN_LIMIT    = 20000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int REPORT_LIMIT   = 10;

	// One output byte as it should appear on the output channel.
	typedef struct {
		logic [BYTE_W-1:0] value;
		logic              tag;
		logic              last;
	} out_beat_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic [BYTE_W-1:0] data_byte;
	logic              out_valid;
	logic              out_stall;
	logic [BYTE_W-1:0] out_byte;
	logic              is_tag;
	logic              last_of_run;

	// Predicted filter settings and row state.
	logic [BPP_W-1:0]  bpp_reg;
	logic [COL_W-1:0]  row_len_reg;
	logic              wide_reg;
	logic              filt_reg;
	logic [BYTE_W-1:0] row_hist [MAX_PIXEL_BYTES];
	logic [COL_W-1:0]  row_col;
	logic [BYTE_W-1:0] held_val;

	// Output bytes predicted but not yet seen.
	out_beat_t due_bytes [$];

	int unsigned in_gap_max;
	int unsigned out_wait_max;
	int unsigned error_count;
	int unsigned bytes_sent;
	int unsigned results_seen;
	int unsigned tags_seen;
	int unsigned swapped_pairs;
	int unsigned reg_writes;

	png_row_sub_filter uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.is_tag      (is_tag),
		.last_of_run (last_of_run)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard stop in case the handshake hangs.
	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("[png_row_sub_filter] ERROR");
		$finish;
	end

	function automatic void flag_error(input string msg);
		error_count++;
		if (error_count <= REPORT_LIMIT) begin
			$display("%0t: %s", $time, msg);
		end
	endfunction

	function automatic int unsigned pick_pace();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 3;
			default: return 17;
		endcase
	endfunction

	// Works out the output bytes of one raw byte and advances the row state.
	task automatic filter_byte(input logic [BYTE_W-1:0] value);
		int unsigned       span;
		int unsigned       len;
		int unsigned       slot;
		logic [BYTE_W-1:0] prev;
		logic [BYTE_W-1:0] diff;
		logic              row_end;
		out_beat_t         batch [$];

		span = (bpp_reg == 0) ? 1 :
			(bpp_reg > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : 32'(bpp_reg);
		len = (row_len_reg == 0) ? 1 : 32'(row_len_reg);
		row_end = (row_col >= len - 1);

		if (row_col == 0) begin
			batch.push_back('{filt_reg ? TAG_SUB : TAG_NONE, 1'b1, 1'b0});
		end

		// Sub filter: subtract the byte one pixel back, zero before the row start.
		slot = row_col % span;
		prev = (row_col < span) ? '0 : row_hist[slot];
		diff = filt_reg ? value - prev : value;
		row_hist[slot] = value;

		// Wide filtered mode holds an even byte and sends the pair swapped.
		if (filt_reg && wide_reg && !row_col[0]) begin
			if (row_end) begin
				batch.push_back('{diff, 1'b0, 1'b0});
			end else begin
				held_val = diff;
			end
		end else begin
			batch.push_back('{diff, 1'b0, 1'b0});
			if (filt_reg && wide_reg) begin
				batch.push_back('{held_val, 1'b0, 1'b0});
				swapped_pairs++;
			end
		end

		if (batch.size() > 0) begin
			batch[batch.size() - 1].last = 1'b1;
		end
		foreach (batch[k]) begin
			due_bytes.push_back(batch[k]);
		end
		row_col = row_end ? '0 : row_col + 1'b1;
	endtask

	// Sends one raw byte after a random gap and predicts it on transfer.
	task automatic send_byte(input logic [BYTE_W-1:0] value);
		int unsigned gap;

		gap = (in_gap_max == 0) ? 0 : $urandom_range(0, in_gap_max);
		if (gap > 0) begin
			in_valid  <= 1'b0;
			data_byte <= 8'($urandom_range(0, 255));
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= value;
		do @(posedge clk); while (in_stall);
		filter_byte(value);
		bytes_sent++;
	endtask

	// Holds the input until every predicted byte has come out.
	task automatic settle();
		in_valid <= 1'b0;
		while (due_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes one register while the block is idle.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cfg_index <= IDX_W'($urandom_range(0, 3));
		cfg_data  <= CFG_W'($urandom);
		case (idx)
			REG_BYTES_PER_PIXEL: bpp_reg = value[BPP_W-1:0];
			REG_ROW_BYTES:       row_len_reg = value[COL_W-1:0];
			REG_WIDE_SAMPLES:    wide_reg = value[0];
			REG_FILTER_ENABLE:   filt_reg = value[0];
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	// Writes all four registers; narrow registers get random upper bits.
	task automatic apply_setup(input int unsigned bpp, input int unsigned len,
			input bit wide, input bit filt);
		logic [CFG_W-1:0] word;

		word = CFG_W'($urandom);
		word[BPP_W-1:0] = BPP_W'(bpp);
		write_reg(REG_BYTES_PER_PIXEL, word);
		write_reg(REG_ROW_BYTES, CFG_W'(len));
		word = CFG_W'($urandom);
		word[0] = wide;
		write_reg(REG_WIDE_SAMPLES, word);
		word = CFG_W'($urandom);
		word[0] = filt;
		write_reg(REG_FILTER_ENABLE, word);
	endtask

	// Reset defaults: one-byte rows, distance one, Sub filter on.
	task automatic test_reset_defaults();
		in_gap_max   = 0;
		out_wait_max = 0;
		send_byte(8'h00);
		send_byte(8'hFF);
	endtask

	// Byte extremes and wrap of the subtraction modulo 256.
	task automatic test_sub_extremes();
		in_gap_max   = 17;
		out_wait_max = 17;
		apply_setup(2, 4, 1'b0, 1'b1);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'hFF);
	endtask

	// Distance zero acts as one, distances above the history depth are clamped.
	task automatic test_distance_clamp();
		apply_setup(0, 2, 1'b0, 1'b1);
		send_byte(8'h10);
		send_byte(8'h05);
		apply_setup(15, 9, 1'b0, 1'b1);
		for (int k = 0; k < 9; k++) begin
			send_byte(8'(k * 37 + 11));
		end
	endtask

	// Wide samples: swapped pairs and an unpaired last byte in an odd row.
	task automatic test_wide_pairs();
		in_gap_max   = 3;
		out_wait_max = 3;
		apply_setup(2, 5, 1'b1, 1'b1);
		send_byte(8'h11);
		send_byte(8'h22);
		send_byte(8'h44);
		send_byte(8'h88);
		send_byte(8'hFF);
	endtask

	// Raw copy with tag zero; wide mode has no effect without filtering.
	task automatic test_unfiltered();
		apply_setup(3, 2, 1'b1, 1'b0);
		send_byte(8'hA5);
		send_byte(8'h5A);
	endtask

	// A zero row length acts as one byte per row.
	task automatic test_zero_row();
		apply_setup(1, 0, 1'b0, 1'b1);
		send_byte(8'h80);
		send_byte(8'h7F);
	endtask

	// Register writes inside a row: dropped and stale held bytes, a changed
	// distance, and a shortened row that ends at the current byte.
	task automatic test_midrow_writes();
		in_gap_max   = 17;
		out_wait_max = 0;
		apply_setup(1, 6, 1'b1, 1'b1);
		send_byte(8'h30);
		write_reg(REG_WIDE_SAMPLES, 20'd0);
		send_byte(8'h31);
		write_reg(REG_WIDE_SAMPLES, 20'd1);
		send_byte(8'h50);
		write_reg(REG_WIDE_SAMPLES, 20'd0);
		send_byte(8'h61);
		send_byte(8'h72);
		write_reg(REG_WIDE_SAMPLES, 20'd1);
		send_byte(8'h83);

		apply_setup(3, 8, 1'b0, 1'b1);
		send_byte(8'h0A);
		send_byte(8'hB0);
		send_byte(8'h0C);
		write_reg(REG_BYTES_PER_PIXEL, 20'd2);
		send_byte(8'hD4);
		write_reg(REG_ROW_BYTES, 20'd2);
		send_byte(8'hE5);
	endtask

	// Random settings and rows of random or ramped bytes, some register
	// writes landing inside a row.
	task automatic test_random_rows();
		int unsigned       start;
		int unsigned       bpp;
		int unsigned       len;
		int unsigned       len_eff;
		int unsigned       n;
		int unsigned       cut;
		bit                ramp;
		logic [BYTE_W-1:0] base;
		logic [BYTE_W-1:0] stride;

		start = bytes_sent;
		while (bytes_sent - start < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: bpp = 0;
				1: bpp = $urandom_range(9, 15);
				default: bpp = $urandom_range(1, 8);
			endcase
			case ($urandom_range(0, 9))
				0: len = 0;
				1: len = 20'hFFFFF;
				2: len = $urandom_range(17, 40);
				default: len = $urandom_range(1, 16);
			endcase
			apply_setup(bpp, len, 1'($urandom_range(0, 1)), ($urandom_range(0, 3) != 0));
			in_gap_max   = pick_pace();
			out_wait_max = pick_pace();

			len_eff = (len == 0) ? 1 : len;
			if (len == 20'hFFFFF) begin
				n = 24;
			end else begin
				n = $urandom_range(1, (3 * len_eff > 48) ? 48 : 3 * len_eff);
			end
			cut    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : n;
			ramp   = ($urandom_range(0, 3) == 0);
			base   = 8'($urandom_range(0, 255));
			stride = 8'($urandom_range(0, 255));

			for (int k = 0; k < n; k++) begin
				if (k == cut) begin
					case ($urandom_range(0, 3))
						0: write_reg(REG_BYTES_PER_PIXEL, CFG_W'($urandom_range(0, 15)));
						1: write_reg(REG_ROW_BYTES, CFG_W'($urandom_range(0, 20)));
						2: write_reg(REG_WIDE_SAMPLES, CFG_W'($urandom_range(0, 1)));
						default: write_reg(REG_FILTER_ENABLE, CFG_W'($urandom_range(0, 1)));
					endcase
				end
				send_byte(ramp ? 8'(base + stride * k) : 8'($urandom_range(0, 255)));
			end

			// A huge row is cut short so that the next byte ends it.
			if (len == 20'hFFFFF) begin
				write_reg(REG_ROW_BYTES, CFG_W'($urandom_range(1, 16)));
			end
		end
	endtask

	// Output side: a random stall before each transfer.
	initial begin : out_side
		int unsigned hold;

		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = (out_wait_max == 0) ? 0 : $urandom_range(0, out_wait_max);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Compares each output transfer with the oldest predicted byte.
	always @(posedge clk) begin : check_out
		out_beat_t want;

		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (is_tag === 1'b1) begin
				tags_seen++;
			end
			if (due_bytes.size() == 0) begin
				flag_error($sformatf("unexpected output byte %02h, tag %b, last %b",
					out_byte, is_tag, last_of_run));
			end else begin
				want = due_bytes.pop_front();
				if (out_byte !== want.value) begin
					flag_error($sformatf("out_byte: expected %02h, got %02h",
						want.value, out_byte));
				end
				if (is_tag !== want.tag) begin
					flag_error($sformatf("is_tag: expected %b, got %b", want.tag, is_tag));
				end
				if (last_of_run !== want.last) begin
					flag_error($sformatf("last_of_run: expected %b, got %b",
						want.last, last_of_run));
				end
			end
		end
	end

	// Test sequence.
	initial begin : main_seq
		int unsigned waited;

		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		data_byte    = '0;
		in_gap_max   = 0;
		out_wait_max = 0;
		error_count  = 0;
		bytes_sent   = 0;
		results_seen = 0;
		tags_seen    = 0;
		swapped_pairs = 0;
		reg_writes   = 0;

		// Predicted state after reset.
		bpp_reg     = BPP_W'(1);
		row_len_reg = COL_W'(1);
		wide_reg    = 1'b0;
		filt_reg    = 1'b1;
		foreach (row_hist[k]) begin
			row_hist[k] = '0;
		end
		row_col  = '0;
		held_val = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_sub_extremes();
		test_distance_clamp();
		test_wide_pairs();
		test_unfiltered();
		test_zero_row();
		test_midrow_writes();
		test_random_rows();

		// Let the output drain, then watch for stray bytes.
		in_valid <= 1'b0;
		waited = 0;
		while (due_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (due_bytes.size() != 0) begin
			flag_error($sformatf("%0d predicted output bytes never arrived",
				due_bytes.size()));
		end

		$display("Sent %0d row bytes and checked %0d output bytes %s",
			bytes_sent, results_seen,
			$sformatf("(%0d row tags, %0d swapped pairs).", tags_seen, swapped_pairs));
		$display("Made %0d register writes over distances 0-15, %s",
			reg_writes, "row lengths 0-1048575, wide and raw modes.");
		if (error_count == 0) begin
			$display("[png_row_sub_filter] OK");
		end else begin
			$display("%0d mismatches in total", error_count);
			$display("[png_row_sub_filter] ERROR");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/prsf_pkg.sv
rtl/core/prsf_out_buf.sv
rtl/core/png_row_sub_filter.sv
dv/png_row_sub_filter_tb.sv
